// ===== src/isr_pkg.sv =====
// Shared types and constants for the interval sample reduction block.
package isr_pkg;

	localparam int SMP_W   = 16;
	localparam int RES_W   = 40;
	localparam int FRAC_W  = 8;
	localparam int CNT_W   = 17;
	localparam int SUM_W   = 33;
	localparam int SQS_W   = 47;
	localparam int MODE_W  = 3;
	localparam int ENG_W   = 80;
	localparam int ENG_Y_W = 64;
	localparam int ITER_W  = 7;

	localparam logic [MODE_W-1:0] MODE_MEAN   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_MAX    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_MIN    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_STDDEV = 3'd3;
	localparam logic [MODE_W-1:0] MODE_SUM    = 3'd4;
	localparam logic [MODE_W-1:0] MODE_COUNT  = 3'd5;

	typedef enum logic [1:0] {
		OP_MUL  = 2'd0,
		OP_DIV  = 2'd1,
		OP_SQRT = 2'd2
	} eng_op_t;

	typedef struct packed {
		logic    start;
		eng_op_t op;
	} eng_req_t;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_ACC  = 9'b000000010,
		ST_DEC  = 9'b000000100,
		ST_P1   = 9'b000001000,
		ST_P2   = 9'b000010000,
		ST_M    = 9'b000100000,
		ST_DV   = 9'b001000000,
		ST_SQ   = 9'b010000000,
		ST_OUT  = 9'b100000000
	} state_t;

endpackage

// ===== src/isr_if.sv =====
// Valid/ready channels for sample input and reduction output.
interface isr_in_if;
	logic                             valid;
	logic                             ready;
	logic signed [isr_pkg::SMP_W-1:0] sample;
	logic                             last;
	logic                             empty_req;
	modport source (output valid, sample, last, empty_req, input ready);
	modport sink (input valid, sample, last, empty_req, output ready);
endinterface

interface isr_out_if;
	logic                             valid;
	logic                             ready;
	logic signed [isr_pkg::RES_W-1:0] result;
	logic                             is_nan;
	logic                             overflow;
	modport source (output valid, result, is_nan, overflow, input ready);
	modport sink (input valid, result, is_nan, overflow, output ready);
endinterface

// ===== src/isr_engine.sv =====
// Iterative arithmetic engine: shift-add multiply, restoring divide, square root.
module isr_engine (
	input  logic                               clk,
	input  logic                               arst_n,
	input  isr_pkg::eng_req_t                  req,
	input  logic [isr_pkg::ENG_W-1:0]          x,
	input  logic [isr_pkg::ENG_Y_W-1:0]        y,
	output logic                               done,
	output logic [isr_pkg::ENG_W-1:0]          prod,
	output logic [isr_pkg::ENG_W-1:0]          quot,
	output logic [isr_pkg::ENG_W-1:0]          root
);

	localparam int W = isr_pkg::ENG_W;

	logic [W-1:0]            a_q, b_q, r_q;
	logic [isr_pkg::ITER_W-1:0] cnt_q;
	logic                    busy_q, done_q;
	isr_pkg::eng_op_t        op_q;

	logic [W-1:0] opa, opb, t_div, t_sqrt;
	logic         sub;
	logic [W:0]   sum;

	assign t_div  = {r_q[W-2:0], a_q[W-1]};
	assign t_sqrt = {r_q[W-3:0], a_q[W-1:W-2]};

	// operand select for the one shared adder
	always_comb begin
		opa = r_q;
		opb = b_q;
		sub = 1'b0;
		case (op_q)
			isr_pkg::OP_MUL: begin
				opa = r_q;
				opb = b_q;
				sub = 1'b0;
			end
			isr_pkg::OP_DIV: begin
				opa = t_div;
				opb = b_q;
				sub = 1'b1;
			end
			isr_pkg::OP_SQRT: begin
				opa = t_sqrt;
				opb = {b_q[W-3:0], 2'b01};
				sub = 1'b1;
			end
			default: begin
				opa = r_q;
				opb = b_q;
				sub = 1'b0;
			end
		endcase
	end

	// carry out high on subtract means opa >= opb
	assign sum = {1'b0, opa} + {1'b0, (sub ? ~opb : opb)} + {{W{1'b0}}, sub};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= isr_pkg::OP_MUL;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				case (req.op)
					isr_pkg::OP_MUL:  cnt_q <= isr_pkg::ITER_W'(31);
					isr_pkg::OP_DIV:  cnt_q <= isr_pkg::ITER_W'(W - 1);
					isr_pkg::OP_SQRT: cnt_q <= isr_pkg::ITER_W'(W / 2 - 1);
					default:          cnt_q <= '0;
				endcase
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			r_q <= '0;
			case (req.op)
				isr_pkg::OP_MUL: begin
					a_q <= W'(y);
					b_q <= x;
				end
				isr_pkg::OP_DIV: begin
					a_q <= x;
					b_q <= W'(y);
				end
				default: begin
					a_q <= x;
					b_q <= '0;
				end
			endcase
		end else if (busy_q) begin
			case (op_q)
				isr_pkg::OP_MUL: begin
					if (a_q[0]) r_q <= sum[W-1:0];
					a_q <= a_q >> 1;
					b_q <= b_q << 1;
				end
				isr_pkg::OP_DIV: begin
					r_q <= sum[W] ? sum[W-1:0] : t_div;
					a_q <= {a_q[W-2:0], sum[W]};
				end
				default: begin
					r_q <= sum[W] ? sum[W-1:0] : t_sqrt;
					a_q <= a_q << 2;
					b_q <= {b_q[W-2:0], sum[W]};
				end
			endcase
		end
	end

	assign done = done_q;
	assign prod = r_q;
	assign quot = a_q;
	assign root = b_q;

endmodule

// ===== src/interval_sample_reduction_core.sv =====
// Top level: interval accumulation and end-of-interval reduction sequencer.
//
// Samples arrive on din as valid/ready beats; a beat with last set closes the
// interval. Each beat is registered and, unless empty_req is set or the count
// is full, folded into count, sum, sum of squares, min and max; ready stays low
// until it is folded. A last beat also computes the mode register's reduction:
//   max, min, sum, count, empty interval: no engine step.
//   mean: one 80-step restoring divide.
//   stddev: three 32-step multiplies, an 80-step divide and a 40-step square
//   root, all on one shared adder.
// The result beat goes out on dout from an output register; while it waits the
// block keeps taking samples of the next interval, and only stalls once the
// next interval's result is ready and the register is still full.
// mode must be written via cfg_we/cfg_data only while idle (not enforced).
// arst_n clears the accumulators, mode and all handshake state at once.
module interval_sample_reduction_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [isr_pkg::MODE_W-1:0]        cfg_data,
	isr_in_if.sink                            din,
	isr_out_if.source                         dout
);

	localparam int SW = isr_pkg::SMP_W;
	localparam int CW = isr_pkg::CNT_W;
	localparam int RW = isr_pkg::RES_W;
	localparam int EW = isr_pkg::ENG_W;
	localparam int YW = isr_pkg::ENG_Y_W;
	localparam logic signed [SW-1:0] SMP_POS = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] SMP_NEG = {1'b1, {(SW-1){1'b0}}};

	isr_pkg::state_t state_q;
	logic [isr_pkg::MODE_W-1:0] mode_q;

	logic signed [SW-1:0]          smp_q;
	logic                          last_q, empty_q;
	logic [CW-1:0]                 cnt_q;
	logic signed [isr_pkg::SUM_W-1:0] sum_q;
	logic [isr_pkg::SQS_W-1:0]     sqs_q;
	logic signed [SW-1:0]          max_q, min_q;
	logic                          lim_q;

	logic [YW-1:0]                 p1_q, d_q;
	logic [YW-1:0]                 m_q;
	logic                          issued_q;

	logic signed [RW-1:0]          res_q;
	logic                          nan_q, ovf_q, ovalid_q;
	logic signed [RW-1:0]          pend_res_q;
	logic                          pend_nan_q, pend_ovf_q;
	logic                          load_out;

	isr_pkg::eng_req_t             ereq;
	logic [EW-1:0]                 ex;
	logic [YW-1:0]                 ey;
	logic                          edone;
	logic [EW-1:0]                 eprod, equot, eroot;

	logic [31:0]                   sum_abs;
	logic [2*SW-1:0]               sq;
	logic                          sum_neg;

	assign sum_neg = sum_q[isr_pkg::SUM_W-1];
	assign sum_abs = sum_neg ? 32'(-sum_q) : 32'(sum_q);
	assign sq      = 32'(smp_q * smp_q);

	assign din.ready = (state_q == isr_pkg::ST_IDLE);

	// output register takes a new beat once it is empty or being drained
	assign load_out = (state_q == isr_pkg::ST_OUT) && (!ovalid_q || dout.ready);

	// engine operands follow the sequencer step
	always_comb begin
		ereq.start = 1'b0;
		ereq.op    = isr_pkg::OP_MUL;
		ex         = '0;
		ey         = '0;
		case (state_q)
			isr_pkg::ST_P1: begin
				ereq.start = !issued_q;
				ex         = EW'(sqs_q);
				ey         = YW'(cnt_q);
			end
			isr_pkg::ST_P2: begin
				ereq.start = !issued_q;
				ex         = EW'(sum_abs);
				ey         = YW'(sum_abs);
			end
			isr_pkg::ST_M: begin
				ereq.start = !issued_q;
				ex         = EW'(cnt_q);
				ey         = YW'(cnt_q - 1'b1);
			end
			isr_pkg::ST_DV: begin
				ereq.start = !issued_q;
				ereq.op    = isr_pkg::OP_DIV;
				if (mode_q == isr_pkg::MODE_MEAN) begin
					ex = EW'({sum_abs, {isr_pkg::FRAC_W{1'b0}}});
					ey = YW'(cnt_q);
				end else begin
					ex = {d_q, {(2*isr_pkg::FRAC_W){1'b0}}};
					ey = m_q;
				end
			end
			isr_pkg::ST_SQ: begin
				ereq.start = !issued_q;
				ereq.op    = isr_pkg::OP_SQRT;
				ex         = EW'(p1_q);
			end
			default: begin
				ereq.start = 1'b0;
			end
		endcase
	end

	isr_engine u_eng (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ereq),
		.x      (ex),
		.y      (ey),
		.done   (edone),
		.prod   (eprod),
		.quot   (equot),
		.root   (eroot)
	);

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mode_q <= isr_pkg::MODE_MEAN;
		else if (cfg_we) mode_q <= cfg_data;
	end

	// sequencer, accumulators and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= isr_pkg::ST_IDLE;
			cnt_q      <= '0;
			sum_q      <= '0;
			sqs_q      <= '0;
			max_q      <= SMP_NEG;
			min_q      <= SMP_POS;
			lim_q      <= 1'b0;
			issued_q   <= 1'b0;
			ovalid_q   <= 1'b0;
			res_q      <= '0;
			nan_q      <= 1'b0;
			ovf_q      <= 1'b0;
			smp_q      <= '0;
			last_q     <= 1'b0;
			empty_q    <= 1'b0;
			p1_q       <= '0;
			d_q        <= '0;
			m_q        <= '0;
			pend_res_q <= '0;
			pend_nan_q <= 1'b0;
			pend_ovf_q <= 1'b0;
		end else begin
			if (load_out) ovalid_q <= 1'b1;
			else if (dout.ready) ovalid_q <= 1'b0;
			case (state_q)
				isr_pkg::ST_IDLE: begin
					if (din.valid) begin
						smp_q   <= din.sample;
						last_q  <= din.last;
						empty_q <= din.empty_req;
						state_q <= isr_pkg::ST_ACC;
					end
				end
				isr_pkg::ST_ACC: begin
					if (!empty_q) begin
						if (cnt_q[CW-1]) begin
							lim_q <= 1'b1;
						end else begin
							cnt_q <= cnt_q + 1'b1;
							sum_q <= sum_q + isr_pkg::SUM_W'(smp_q);
							sqs_q <= sqs_q + isr_pkg::SQS_W'(sq);
							if (smp_q > max_q) max_q <= smp_q;
							if (smp_q < min_q) min_q <= smp_q;
						end
					end
					state_q <= last_q ? isr_pkg::ST_DEC : isr_pkg::ST_IDLE;
				end
				isr_pkg::ST_DEC: begin
					pend_ovf_q <= lim_q;
					pend_nan_q <= 1'b0;
					pend_res_q <= '0;
					state_q    <= isr_pkg::ST_OUT;
					if (cnt_q == '0) begin
						pend_nan_q <= 1'b1;
					end else begin
						case (mode_q)
							isr_pkg::MODE_MEAN: state_q <= isr_pkg::ST_DV;
							isr_pkg::MODE_MAX:
								pend_res_q <= {{(RW-SW-isr_pkg::FRAC_W){max_q[SW-1]}},
									max_q, {isr_pkg::FRAC_W{1'b0}}};
							isr_pkg::MODE_MIN:
								pend_res_q <= {{(RW-SW-isr_pkg::FRAC_W){min_q[SW-1]}},
									min_q, {isr_pkg::FRAC_W{1'b0}}};
							isr_pkg::MODE_STDDEV: begin
								if (cnt_q != CW'(1)) state_q <= isr_pkg::ST_P1;
							end
							isr_pkg::MODE_SUM:
								pend_res_q <= {sum_q[RW-isr_pkg::FRAC_W-1:0],
									{isr_pkg::FRAC_W{1'b0}}};
							isr_pkg::MODE_COUNT:
								pend_res_q <= {{(RW-CW-isr_pkg::FRAC_W){1'b0}},
									cnt_q, {isr_pkg::FRAC_W{1'b0}}};
							default: pend_res_q <= '0;
						endcase
					end
				end
				isr_pkg::ST_P1: begin
					if (!issued_q) issued_q <= 1'b1;
					else if (edone) begin
						issued_q <= 1'b0;
						p1_q     <= eprod[YW-1:0];
						state_q  <= isr_pkg::ST_P2;
					end
				end
				isr_pkg::ST_P2: begin
					if (!issued_q) issued_q <= 1'b1;
					else if (edone) begin
						issued_q <= 1'b0;
						d_q      <= p1_q - eprod[YW-1:0];
						state_q  <= isr_pkg::ST_M;
					end
				end
				isr_pkg::ST_M: begin
					if (!issued_q) issued_q <= 1'b1;
					else if (edone) begin
						issued_q <= 1'b0;
						m_q      <= eprod[YW-1:0];
						state_q  <= isr_pkg::ST_DV;
					end
				end
				isr_pkg::ST_DV: begin
					if (!issued_q) issued_q <= 1'b1;
					else if (edone) begin
						issued_q <= 1'b0;
						if (mode_q == isr_pkg::MODE_MEAN) begin
							pend_res_q <= sum_neg ? -RW'(equot) : RW'(equot);
							state_q    <= isr_pkg::ST_OUT;
						end else begin
							p1_q    <= equot[YW-1:0];
							state_q <= isr_pkg::ST_SQ;
						end
					end
				end
				isr_pkg::ST_SQ: begin
					if (!issued_q) issued_q <= 1'b1;
					else if (edone) begin
						issued_q   <= 1'b0;
						pend_res_q <= RW'(eroot);
						state_q    <= isr_pkg::ST_OUT;
					end
				end
				isr_pkg::ST_OUT: begin
					// load the output register once it is free, then reopen
					if (load_out) begin
						res_q    <= pend_res_q;
						nan_q    <= pend_nan_q;
						ovf_q    <= pend_ovf_q;
						cnt_q    <= '0;
						sum_q    <= '0;
						sqs_q    <= '0;
						max_q    <= SMP_NEG;
						min_q    <= SMP_POS;
						lim_q    <= 1'b0;
						state_q  <= isr_pkg::ST_IDLE;
					end
				end
				default: state_q <= isr_pkg::ST_IDLE;
			endcase
		end
	end

	assign dout.valid    = ovalid_q;
	assign dout.result   = res_q;
	assign dout.is_nan   = nan_q;
	assign dout.overflow = ovf_q;

endmodule
